[hdl/fsp_pkg.sv]
// shared types, character codes and length codes for the format specifier parser
// no dependencies
package fsp_pkg;

  localparam int NUMBER_BITS_DEF = 16;
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_L = 8'h6C;
  localparam logic [7:0] CH_CAP_L = 8'h4C;
  localparam logic [7:0] CH_LOW_H = 8'h68;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_H    = 3'd1;
  localparam logic [2:0] LEN_HH   = 3'd2;
  localparam logic [2:0] LEN_L    = 3'd3;
  localparam logic [2:0] LEN_LL   = 3'd4;
  localparam logic [2:0] LEN_CAPL = 3'd5;

  localparam logic [4:0] FLAG_PLUS  = 5'b00001;
  localparam logic [4:0] FLAG_MINUS = 5'b00010;
  localparam logic [4:0] FLAG_ALT   = 5'b00100;
  localparam logic [4:0] FLAG_SPACE = 5'b01000;
  localparam logic [4:0] FLAG_ZPAD  = 5'b10000;

  typedef enum logic [1:0] {
    LTR_NONE,
    LTR_LOW_L,
    LTR_LOW_H,
    LTR_CAP_L
  } letter_t;

  typedef struct packed {
    logic       start_marker;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic        flag_plus;
    logic        flag_minus;
    logic        flag_alternate;
    logic        flag_space;
    logic        flag_zero_pad;
    logic [15:0] field_width;
    logic [15:0] precision_value;
    logic        precision_given;
    logic [2:0]  length_code;
    logic [7:0]  end_char;
    logic [7:0]  consumed_count;
  } result_t;

  typedef struct packed {
    logic       start;
    logic [7:0] ch;
    logic [4:0] flag_mask;
    logic       is_digit;
    logic [3:0] digit;
    logic       is_dot;
    letter_t    letter;
  } entry_t;

endpackage

[hdl/fsp_front.sv]
// front end: accepts characters and classifies them into queue entries
// depends on fsp_pkg
module fsp_front (
  input  logic           item_valid,
  input  fsp_pkg::item_t item,
  input  logic           queue_full,
  output logic           item_stall,
  output logic           push,
  output fsp_pkg::entry_t entry
);
  import fsp_pkg::*;

  logic [7:0] c;
  logic [7:0] rel;

  assign c          = item.char_in;
  assign rel        = c - CH_ZERO;
  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;

  always_comb begin
    entry.start     = item.start_marker;
    entry.ch        = c;
    entry.is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    entry.digit     = rel[3:0];
    entry.is_dot    = (c == CH_DOT);
    entry.flag_mask = '0;
    case (c)
      CH_PLUS:  entry.flag_mask = FLAG_PLUS;
      CH_MINUS: entry.flag_mask = FLAG_MINUS;
      CH_HASH:  entry.flag_mask = FLAG_ALT;
      CH_SPACE: entry.flag_mask = FLAG_SPACE;
      CH_ZERO:  entry.flag_mask = FLAG_ZPAD;
      default:  entry.flag_mask = '0;
    endcase
    case (c)
      CH_LOW_L: entry.letter = LTR_LOW_L;
      CH_LOW_H: entry.letter = LTR_LOW_H;
      CH_CAP_L: entry.letter = LTR_CAP_L;
      default:  entry.letter = LTR_NONE;
    endcase
  end

endmodule

[hdl/fsp_queue.sv]
// short fifo of classified entries between front and back
// depends on fsp_pkg
module fsp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fsp_pkg::entry_t push_entry,
  input  logic            pop,
  output fsp_pkg::entry_t head,
  output logic            not_empty,
  output logic            full
);
  import fsp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  entry_t        mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head      = mem[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> count != CW'(QUEUE_DEPTH))
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> count == $past(count) + CW'($past(push)) - CW'($past(pop)))
    else $error("queue count out of step");

endmodule

[hdl/fsp_back.sv]
// back end: parse state machine and result register
// depends on fsp_pkg
module fsp_back #(
  parameter int NUMBER_BITS = fsp_pkg::NUMBER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  fsp_pkg::entry_t  head,
  input  logic             not_empty,
  output logic             pop,
  input  logic             result_stall,
  output logic             result_valid,
  output fsp_pkg::result_t result
);
  import fsp_pkg::*;

  localparam int NB = NUMBER_BITS;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_FLAGS,
    PH_WIDTH,
    PH_DOT,
    PH_PREC,
    PH_LEN2,
    PH_DONE
  } phase_t;

  phase_t        phase, phase_next, ph;
  logic [4:0]    flags, flags_next, fl;
  logic [NB-1:0] wacc, wacc_next, wa;
  logic [NB-1:0] pacc, pacc_next, pa;
  logic          pseen, pseen_next, ps;
  logic [2:0]    len_kind, len_kind_next, lk;
  logic [7:0]    cnt, cnt_next, cn;
  logic          emit;
  logic [NB-1:0] acc_in, acc_out;
  logic [NB+3:0] acc_wide;
  logic [NB+15:0] wacc_ext, pacc_ext;

  assign pop = not_empty && (!result_valid || !result_stall);

  always_comb begin
    ph = phase;
    fl = flags;
    wa = wacc;
    pa = pacc;
    ps = pseen;
    lk = len_kind;
    cn = cnt;
    if (head.start) begin
      ph = PH_FLAGS;
      fl = '0;
      wa = '0;
      pa = '0;
      ps = 1'b0;
      lk = LEN_NONE;
      cn = '0;
    end
  end

  // one multiply-by-ten-and-add shared by width and precision
  always_comb begin
    acc_in   = (ph inside {PH_FLAGS, PH_WIDTH}) ? wa : pa;
    acc_wide = ({4'b0, acc_in} << 3) + ({4'b0, acc_in} << 1) + (NB + 4)'(head.digit);
    acc_out  = (acc_wide > {4'b0, {NB{1'b1}}}) ? {NB{1'b1}} : acc_wide[NB-1:0];
  end

  always_comb begin
    phase_next    = ph;
    flags_next    = fl;
    wacc_next     = wa;
    pacc_next     = pa;
    pseen_next    = ps;
    len_kind_next = lk;
    cnt_next      = cn;
    emit          = 1'b0;
    if (ph != PH_IDLE) begin
      if (ph == PH_FLAGS && head.flag_mask != '0) begin
        flags_next = fl | head.flag_mask;
      end else if ((ph inside {PH_FLAGS, PH_WIDTH}) && head.is_digit) begin
        wacc_next  = acc_out;
        phase_next = PH_WIDTH;
      end else if ((ph inside {PH_FLAGS, PH_WIDTH}) && head.is_dot) begin
        phase_next = PH_DOT;
      end else if ((ph inside {PH_DOT, PH_PREC}) && head.is_digit) begin
        pacc_next  = acc_out;
        pseen_next = 1'b1;
        phase_next = PH_PREC;
      end else if ((ph inside {PH_FLAGS, PH_WIDTH, PH_DOT, PH_PREC}) &&
                   head.letter != LTR_NONE) begin
        case (head.letter)
          LTR_LOW_L: len_kind_next = LEN_L;
          LTR_LOW_H: len_kind_next = LEN_H;
          default:   len_kind_next = LEN_CAPL;
        endcase
        phase_next = PH_LEN2;
      end else if (ph == PH_LEN2 &&
                   (head.letter == LTR_LOW_L || head.letter == LTR_LOW_H)) begin
        len_kind_next = (head.letter == LTR_LOW_L) ? LEN_LL : LEN_HH;
        phase_next    = PH_DONE;
      end else begin
        emit       = 1'b1;
        phase_next = PH_IDLE;
      end
      if (!emit && cn != 8'hFF) begin
        cnt_next = cn + 1'b1;
      end
    end
  end

  assign wacc_ext = {16'b0, wa};
  assign pacc_ext = {16'b0, pa};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (pop) begin
        phase    <= phase_next;
        flags    <= flags_next;
        wacc     <= wacc_next;
        pacc     <= pacc_next;
        pseen    <= pseen_next;
        len_kind <= len_kind_next;
        cnt      <= cnt_next;
        if (emit) begin
          result_valid           <= 1'b1;
          result.flag_plus       <= fl[0];
          result.flag_minus      <= fl[1];
          result.flag_alternate  <= fl[2];
          result.flag_space      <= fl[3];
          result.flag_zero_pad   <= fl[4];
          result.field_width     <= wacc_ext[15:0];
          result.precision_value <= pacc_ext[15:0];
          result.precision_given <= ps;
          result.length_code     <= lk;
          result.end_char        <= head.ch;
          result.consumed_count  <= cn;
        end
      end
    end
  end

  a_new_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && result_valid && !$past(result_valid) |-> $past(pop))
    else $error("result appeared without a popped entry");

  a_emit_goes_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $past(pop) && $past(emit) |-> phase == PH_IDLE && result_valid)
    else $error("result emitted without returning to idle");

endmodule

[hdl/format_specifier_parser_unit.sv]
// top level of the format specifier parser: front end, queue, back end
// depends on fsp_pkg, fsp_front, fsp_queue, fsp_back
// each character is queued; result_valid is set when the spec's final character is popped
// throughput: one character per cycle while the result register is not stalled
// a 4-entry queue decouples input acceptance from a stalled result register
// reset (synchronous) empties the queue, drops any pending result and idles the parser
module format_specifier_parser_unit #(
  parameter int NUMBER_BITS = fsp_pkg::NUMBER_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  fsp_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output fsp_pkg::result_t result
);
  import fsp_pkg::*;

  logic   push;
  logic   pop;
  logic   full;
  logic   not_empty;
  entry_t push_entry;
  entry_t head;

  fsp_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .queue_full (full),
    .item_stall (item_stall),
    .push       (push),
    .entry      (push_entry)
  );

  fsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .full       (full)
  );

  fsp_back #(
    .NUMBER_BITS (NUMBER_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .not_empty    (not_empty),
    .pop          (pop),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
